@@ rtl/spq_pkg.sv @@
// types and constants shared by the sorted priority queue modules
package spq_pkg;

  localparam int unsigned CapW = 7;
  localparam logic [CapW-1:0] CAPACITY_RESET = 7'd64;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_t;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] value;
    logic signed [15:0] priority_req;
  } spq_req_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    spq_status_t        status;
    logic [CapW-1:0]    count;
  } spq_rsp_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } spq_entry_t;

  typedef struct packed {
    logic       enq;
    logic       deq;
    spq_entry_t entry;
  } spq_ctrl_t;

endpackage

@@ rtl/spq_cell.sv @@
// one slot of the sorted row: holds an entry, shifts right on insert, left on removal
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  spq_ctrl_t  ctrl,
  input  logic       occupied,
  input  spq_entry_t left_entry,
  input  logic       left_lower,
  input  spq_entry_t right_entry,
  output spq_entry_t entry,
  output logic       lower
);

  // strictly lower priority than the incoming entry, or empty slot
  always_comb begin
    lower = !occupied || (entry.prio < ctrl.entry.prio);
  end

  always_ff @(posedge clk) begin
    if (ctrl.enq) begin
      if (lower) begin
        entry <= left_lower ? left_entry : ctrl.entry;
      end
    end else if (ctrl.deq) begin
      entry <= right_entry;
    end
  end

endmodule

@@ rtl/sorted_priority_queue.sv @@
// Sorted priority queue: a row of DEPTH cells kept in descending priority order, front at
// cell 0. One request (enqueue or dequeue) is taken every clock cycle while no response is
// stalled; its response is registered and appears the cycle after the request is accepted,
// and a new request is taken while that response waits if it is taken in the same cycle.
// An enqueue compares its priority against every cell at once and each cell either keeps
// its entry, takes the new one or takes its left neighbour's; a dequeue shifts the row
// one cell to the front. That single broadcast compare across the row sets the cycle.
// Equal priorities leave in arrival order. Enqueues beyond min(capacity, DEPTH) are
// dropped with status full; a dequeue on an empty queue returns zero with status empty.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  spq_req_t        req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output spq_rsp_t        rsp,
  input  logic            cfg_we,
  input  logic [CapW-1:0] cfg_wdata
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > CapW) ? CW : CapW;

  logic [CapW-1:0] capacity;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  spq_ctrl_t       ctrl;
  spq_rsp_t        rsp_next;
  logic            fire;
  logic            full;
  logic            empty;

  spq_entry_t      cell_entry [DEPTH];
  logic [DEPTH-1:0] cell_lower;

  assign req_ready = !rsp_valid || rsp_ready;
  assign fire      = req_valid && req_ready;
  assign empty     = (count == '0);
  assign full      = (LW'(count) >= LW'(capacity)) || (LW'(count) >= LW'(DEPTH));

  always_comb begin
    ctrl.enq         = fire && (req.mode == MODE_ENQ) && !full;
    ctrl.deq         = fire && (req.mode == MODE_DEQ) && !empty;
    ctrl.entry.value = req.value;
    ctrl.entry.prio  = req.priority_req;
  end

  always_comb begin
    count_next = count;
    if (ctrl.enq) begin
      count_next = count + CW'(1);
    end else if (ctrl.deq) begin
      count_next = count - CW'(1);
    end
  end

  always_comb begin
    rsp_next.out_value = '0;
    rsp_next.status    = ST_DONE;
    rsp_next.count     = CapW'(count_next);
    case (req.mode)
      MODE_ENQ: begin
        if (full) begin
          rsp_next.status = ST_FULL;
        end
      end
      MODE_DEQ: begin
        if (empty) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          rsp_next.out_value = cell_entry[0].value;
        end
      end
      default: begin
        rsp_next.status = ST_DONE;
      end
    endcase
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      spq_entry_t left_entry;
      spq_entry_t right_entry;
      logic       left_lower;

      if (i == 0) begin : g_first
        assign left_entry = ctrl.entry;
        assign left_lower = 1'b0;
      end else begin : g_mid
        assign left_entry = cell_entry[i-1];
        assign left_lower = cell_lower[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign right_entry = ctrl.entry;
      end else begin : g_inner
        assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (CW'(i) < count),
        .left_entry  (left_entry),
        .left_lower  (left_lower),
        .right_entry (right_entry),
        .entry       (cell_entry[i]),
        .lower       (cell_lower[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAPACITY_RESET;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      count <= count_next;
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

endmodule

@@ rtl/spq_checker.sv @@
// port-level checks for the sorted priority queue, bound to the top level
module spq_checker
  import spq_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input spq_rsp_t        rsp
);

  // a pending response is held until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response dropped or changed while stalled");

  // every accepted request gives a response on the next cycle
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("no response after accepted request");

  // no request taken while an untaken response is held
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> !rsp_valid || rsp_ready)
    else $error("request accepted over a pending response");

  // an empty dequeue reports zero value and zero count
  a_empty_resp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_EMPTY |-> rsp.out_value == '0 && rsp.count == '0)
    else $error("empty response with nonzero value or count");

  // a dropped enqueue returns no value
  a_full_resp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.out_value == '0)
    else $error("full response with nonzero value");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

@@ bench/spq_checker.sv @@
// checker for the sorted priority queue: predicts each response and compares it with the block
module spq_scoreboard
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_ready,
  input  spq_req_t        req,
  input  logic            rsp_valid,
  input  logic            rsp_ready,
  input  spq_rsp_t        rsp,
  input  logic            cfg_we,
  input  logic [CapW-1:0] cfg_wdata,
  output int              mismatches,
  output int              awaited
);

  spq_entry_t      held [DEPTH];
  int unsigned     held_count;
  logic [CapW-1:0] cap_shadow;
  spq_rsp_t        awaited_rsp [$];

  function automatic spq_rsp_t serve(spq_req_t r);
    spq_rsp_t    res;
    int unsigned limit;
    int unsigned pos;
    res.out_value = '0;
    res.status    = ST_DONE;
    if (r.mode == MODE_ENQ) begin
      limit = (cap_shadow < DEPTH) ? cap_shadow : DEPTH;
      if (held_count >= limit) begin
        res.status = ST_FULL;
      end else begin
        pos = held_count;
        for (int i = 0; i < held_count; i++) begin
          if (held[i].prio < r.priority_req) begin
            pos = i;
            break;
          end
        end
        for (int i = held_count; i > pos; i--) held[i] = held[i-1];
        held[pos].value = r.value;
        held[pos].prio  = r.priority_req;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.out_value = held[0].value;
        for (int i = 0; i + 1 < held_count; i++) held[i] = held[i+1];
        held_count--;
      end
    end
    res.count = held_count[CapW-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    spq_rsp_t exp_rsp;
    if (rst) begin
      held_count = 0;
      cap_shadow = CAPACITY_RESET;
      awaited_rsp.delete();
      mismatches <= 0;
      awaited    <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp.size() == 0) begin
          $error("response with nothing awaited: out_value %0d status %0d count %0d",
                 rsp.out_value, rsp.status, rsp.count);
          mismatches <= mismatches + 1;
        end else begin
          exp_rsp = awaited_rsp.pop_front();
          if (rsp.out_value !== exp_rsp.out_value) begin
            $error("out_value expected %0d actual %0d", exp_rsp.out_value, rsp.out_value);
          end
          if (rsp.status !== exp_rsp.status) begin
            $error("status expected %0d actual %0d", exp_rsp.status, rsp.status);
          end
          if (rsp.count !== exp_rsp.count) begin
            $error("count expected %0d actual %0d", exp_rsp.count, rsp.count);
          end
          if (rsp !== exp_rsp) mismatches <= mismatches + 1;
        end
      end
      if (req_valid && req_ready) awaited_rsp.push_back(serve(req));
      if (cfg_we) cap_shadow = cfg_wdata;
      awaited <= awaited_rsp.size();
    end
  end

endmodule

@@ bench/testbench.sv @@
// testbench top: drives requests and capacity writes into the priority queue and gives the verdict
module testbench;
  import spq_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 160;

  logic            clk;
  logic            rst;
  logic            req_valid;
  logic            req_ready;
  spq_req_t        req;
  logic            rsp_valid;
  logic            rsp_ready;
  spq_rsp_t        rsp;
  logic            cfg_we;
  logic [CapW-1:0] cfg_wdata;
  int              mismatches;
  int              awaited;

  bit quiet;
  int stuck_cycles;

  sorted_priority_queue uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  spq_scoreboard scoreboard (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // response side, with one long hold-off once enough responses have been taken
  initial begin
    int gap;
    int taken;
    rsp_ready = 1'b0;
    taken     = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    forever begin
      if (taken == HOLD_AFTER) begin
        rsp_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        rsp_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ready = 1'b1;
      do @(posedge clk); while (!(rsp_valid && rsp_ready));
      taken++;
      @(negedge clk);
    end
  end

  task automatic send(input spq_req_t r);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       = r;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic enq(input logic [31:0] v, input logic [15:0] p);
    spq_req_t r;
    r.mode         = MODE_ENQ;
    r.value        = v;
    r.priority_req = p;
    send(r);
  endtask

  task automatic deq();
    spq_req_t r;
    r.mode         = MODE_DEQ;
    r.value        = $urandom;
    r.priority_req = 16'($urandom);
    send(r);
  endtask

  task automatic drain();
    req_valid = 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CapW-1:0] v);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic logic [15:0] pick_prio();
    logic [15:0] p;
    case ($urandom_range(0, 3))
      0: p = 16'($urandom_range(0, 6) - 3);
      1: p = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: p = 16'($urandom);
    endcase
    return p;
  endfunction

  initial begin
    logic [CapW-1:0] caps [10];
    int enq_pct;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    quiet     = 1'b0;
    caps = '{7'd127, 7'd64, 7'd0, 7'd5, 7'd1, 7'd2, 7'd64, 7'd127, 7'd33, 7'd64};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, ordering, full, empty, lowered capacity, zero capacity
    set_capacity(7'd3);
    deq();
    enq(32'h7FFF_FFFF, 16'h7FFF);
    enq(32'h8000_0000, 16'h8000);
    enq(32'h0000_0000, 16'h0000);
    enq(32'hFFFF_FFFF, 16'h7FFF);
    deq();
    deq();
    deq();
    deq();
    enq(32'd1, 16'd5);
    enq(32'd2, 16'd5);
    enq(32'd3, 16'd5);
    set_capacity(7'd1);
    enq(32'd4, 16'h7FFF);
    deq();
    deq();
    enq(32'd5, 16'd9);
    deq();
    enq(32'hA5A5_5A5A, 16'hFFFF);
    deq();
    set_capacity(7'd0);
    enq(32'h1234_5678, 16'd1);
    deq();

    // random phases alternating between filling and draining
    for (int ph = 0; ph < 11; ph++) begin
      set_capacity(ph < 10 ? caps[ph] : 7'($urandom_range(0, 127)));
      enq_pct = (ph % 2 == 0) ? 82 : 35;
      for (int i = 0; i < 105; i++) begin
        if (i % 35 == 0) quiet = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 99) < enq_pct) begin
          enq($urandom, pick_prio());
        end else begin
          deq();
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
bench/spq_checker.sv
bench/testbench.sv
